@@ hw/rtl/fpssd_pkg.sv @@
// Package for the fixed-point to seven-segment digit writer.
// Holds field widths, driver register codes, writer job type and state enum.
// No dependencies.
package fpssd_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  localparam int unsigned VALUE_W = 24;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IDX_W   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_PLACES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_OFFSET   = 2'd1;

  localparam logic [CFG_W-1:0] DECIMAL_PLACES_RST = 3'd1;
  localparam logic [CFG_W-1:0] DIGIT_OFFSET_RST   = 3'd0;

  // display driver codes
  localparam logic [ADDR_W-1:0] SCAN_LIMIT_ADDR = 4'hB;
  localparam logic [DATA_W-1:0] SCAN_LIMIT_DATA = 8'h07;
  localparam logic [DATA_W-1:0] DOT_DATA        = 8'h80;

  typedef struct packed {
    logic             below_one;
    logic [CFG_W-1:0] dec;
    logic [CFG_W-1:0] offset;
  } wr_job_t;

  typedef enum logic [1:0] {
    WR_IDLE,
    WR_SCAN,
    WR_DOT,
    WR_DIGIT
  } wr_state_e;

  function automatic longint unsigned pow10(input int unsigned e);
    longint unsigned p;
    p = 1;
    for (int unsigned k = 0; k < e; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // bits to hold ten times the largest displayable number plus a digit
  function automatic int unsigned num_width(input int unsigned md);
    return $clog2(pow10(md + 1));
  endfunction

endpackage

@@ hw/rtl/fpssd_scale.sv @@
// Decimal scaling sequencer: one fractional decimal digit per cycle.
// Builds min(int*10^dec + trunc(frac*10^dec), 10^MAX_DIGITS-1). Uses fpssd_pkg.
module fpssd_scale #(
  parameter int unsigned MAX_DIGITS = fpssd_pkg::MAX_DIGITS_DEF,
  parameter int unsigned FRAC_BITS  = fpssd_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [fpssd_pkg::VALUE_W-1:0]                 value_i,
  input  logic [fpssd_pkg::CFG_W-1:0]                   dec_i,
  output logic                                          busy_o,
  output logic                                          done_o,
  output logic [fpssd_pkg::num_width(MAX_DIGITS)-1:0]   num_o
);
  import fpssd_pkg::*;

  localparam int unsigned NW = num_width(MAX_DIGITS);
  localparam int unsigned IW = VALUE_W - FRAC_BITS;
  localparam int unsigned CW = (NW > IW) ? NW : IW;
  localparam logic [NW-1:0] LIMIT = NW'(pow10(MAX_DIGITS) - 1);

  logic                 busy_q, busy_d;
  logic [CFG_W-1:0]     steps_q, steps_d;
  logic [NW-1:0]        n_q, n_d;
  logic [FRAC_BITS-1:0] r_q, r_d;

  logic [IW-1:0]          ipart;
  logic [FRAC_BITS+3:0]   r10;
  logic [NW-1:0]          n10;

  assign ipart = value_i[VALUE_W-1:FRAC_BITS];

  always_comb begin
    // remainder times ten: the top nibble is the next decimal digit
    r10 = ({4'b0, r_q} << 3) + ({4'b0, r_q} << 1);
    n10 = (n_q << 3) + (n_q << 1) + NW'(r10[FRAC_BITS+3:FRAC_BITS]);

    busy_d  = busy_q;
    steps_d = steps_q;
    n_d     = n_q;
    r_d     = r_q;
    done_o  = 1'b0;

    if (start_i) begin
      busy_d  = 1'b1;
      steps_d = dec_i;
      r_d     = value_i[FRAC_BITS-1:0];
      if (CW'(ipart) > CW'(LIMIT)) begin
        n_d = LIMIT;
      end else begin
        n_d = NW'(ipart);
      end
    end else if (busy_q) begin
      if (steps_q == '0) begin
        done_o = 1'b1;
        busy_d = 1'b0;
      end else begin
        steps_d = steps_q - 1'b1;
        r_d     = r10[FRAC_BITS-1:0];
        // saturation is sticky since the sum only grows
        n_d     = (n10 > LIMIT) ? LIMIT : n10;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    n_q     <= n_d;
    r_q     <= r_d;
  end

  assign busy_o = busy_q;
  assign num_o  = n_q;

endmodule

@@ hw/rtl/fpssd_bcd.sv @@
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on fpssd_pkg for the number width.
module fpssd_bcd #(
  parameter int unsigned MAX_DIGITS = fpssd_pkg::MAX_DIGITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [fpssd_pkg::num_width(MAX_DIGITS)-1:0] num_i,
  output logic                                        busy_o,
  output logic                                        done_o,
  output logic [4*MAX_DIGITS-1:0]                     digits_o
);
  import fpssd_pkg::*;

  localparam int unsigned NW    = num_width(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(NW + 1);
  localparam int unsigned BW    = 4 * MAX_DIGITS;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    bin_q, bin_d;
  logic [BW-1:0]    bcd_q, bcd_d;
  logic [BW-1:0]    adj;

  always_comb begin
    for (int unsigned j = 0; j < MAX_DIGITS; j++) begin
      adj[4*j +: 4] = (bcd_q[4*j +: 4] >= 4'd5) ? bcd_q[4*j +: 4] + 4'd3 : bcd_q[4*j +: 4];
    end

    busy_d = busy_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    done_o = 1'b0;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NW);
      bin_d  = num_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        done_o = 1'b1;
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        bcd_d = {adj[BW-2:0], bin_q[NW-1]};
        bin_d = bin_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o   = busy_q;
  assign digits_o = bcd_q;

endmodule

@@ hw/rtl/fpssd_writer.sv @@
// Register write sequencer: scan limit, optional dot-zero, then digits.
// Digits leave a shift register one nibble per transfer. Uses fpssd_pkg.
module fpssd_writer #(
  parameter int unsigned MAX_DIGITS = fpssd_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [4*MAX_DIGITS-1:0]         digits_i,
  input  fpssd_pkg::wr_job_t              job_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fpssd_pkg::ADDR_W-1:0]    reg_addr_o,
  output logic [fpssd_pkg::DATA_W-1:0]    reg_data_o,
  output logic                            last_write_o
);
  import fpssd_pkg::*;

  localparam int unsigned BW = 4 * MAX_DIGITS;

  wr_state_e        state_q, state_d;
  logic [BW-1:0]    sh_q, sh_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] last_idx_q, last_idx_d;
  wr_job_t          job_q, job_d;

  logic [IDX_W-1:0] top_idx;
  logic             xfer;
  logic             dot;

  // highest nonzero digit; a zero value still shows one digit
  always_comb begin
    top_idx = '0;
    for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
      if (digits_i[4*i +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign xfer = out_valid_o && !out_stall_i;
  assign dot  = !job_q.below_one && (idx_q == job_q.dec);

  always_comb begin
    state_d      = state_q;
    sh_d         = sh_q;
    idx_d        = idx_q;
    last_idx_d   = last_idx_q;
    job_d        = job_q;
    out_valid_o  = 1'b0;
    reg_addr_o   = SCAN_LIMIT_ADDR;
    reg_data_o   = SCAN_LIMIT_DATA;
    last_write_o = 1'b0;

    case (state_q)
      WR_IDLE: begin
        if (start_i) begin
          state_d    = WR_SCAN;
          sh_d       = digits_i;
          idx_d      = '0;
          last_idx_d = top_idx;
          job_d      = job_i;
        end
      end
      WR_SCAN: begin
        out_valid_o = 1'b1;
        if (xfer) begin
          state_d = job_q.below_one ? WR_DOT : WR_DIGIT;
        end
      end
      WR_DOT: begin
        out_valid_o = 1'b1;
        reg_addr_o  = ADDR_W'(job_q.offset) + 4'd2;
        reg_data_o  = DOT_DATA;
        if (xfer) begin
          state_d = WR_DIGIT;
        end
      end
      WR_DIGIT: begin
        out_valid_o  = 1'b1;
        reg_addr_o   = ADDR_W'(job_q.offset) + ADDR_W'(idx_q) + 4'd1;
        reg_data_o   = {dot, 3'b000, sh_q[3:0]};
        last_write_o = (idx_q == last_idx_q);
        if (xfer) begin
          if (idx_q == last_idx_q) begin
            state_d = WR_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            sh_d  = sh_q >> 4;
          end
        end
      end
      default: begin
        state_d = WR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    idx_q      <= idx_d;
    last_idx_q <= last_idx_d;
    job_q      <= job_d;
  end

  assign busy_o = (state_q != WR_IDLE);

endmodule

@@ hw/rtl/fixed_point_to_seven_segment_digits.sv @@
// Fixed-point to seven-segment digit writer, top level.
// Instantiates fpssd_scale, fpssd_bcd and fpssd_writer; uses fpssd_pkg.
//
// Usage: present an unsigned fixed-point magnitude on value_i with in_valid_i;
// it transfers when in_stall_o is low. The block then produces a sequence of
// display driver register writes on reg_addr_o/reg_data_o, each transferred
// when out_valid_o is high and out_stall_i is low; last_write_o marks the final
// write of the sequence (scan limit, optional dot-zero, one write per digit).
// Only one value is in flight: in_stall_o stays high from the transfer until
// the last write of that value has been taken.
// Order: the scaling sequencer works through decimal_places decimal digits (one
// decimal digit per cycle), then the bit-serial BCD converter handles
// num_width(MAX_DIGITS) bits (one bit per cycle), then the first write shows up.
// A value needs 2..9 register writes.
// A stall on the output simply holds the current write; nothing is dropped.
// Configuration: cfg_valid_i with cfg_index_i (0 decimal places, 1 digit
// offset) and cfg_data_i; cfg_ready_o is always high; write only while idle.
// Reset: decimal places 1, digit offset 0, no value in flight.
module fixed_point_to_seven_segment_digits #(
  parameter int unsigned MAX_DIGITS = fpssd_pkg::MAX_DIGITS_DEF,
  parameter int unsigned FRAC_BITS  = fpssd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpssd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fpssd_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fpssd_pkg::VALUE_W-1:0]     value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fpssd_pkg::ADDR_W-1:0]      reg_addr_o,
  output logic [fpssd_pkg::DATA_W-1:0]      reg_data_o,
  output logic                              last_write_o
);
  import fpssd_pkg::*;

  localparam int unsigned NW = num_width(MAX_DIGITS);

  logic [CFG_W-1:0] dec_q, dec_d;
  logic [CFG_W-1:0] off_q, off_d;
  wr_job_t          job_q, job_d;

  logic          in_xfer;
  logic          scale_busy, scale_done;
  logic          bcd_busy, bcd_done;
  logic          wr_busy;
  logic [NW-1:0] num;
  logic [4*MAX_DIGITS-1:0] digits;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = scale_busy || bcd_busy || wr_busy;
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_comb begin
    dec_d = dec_q;
    off_d = off_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DECIMAL_PLACES: dec_d = cfg_data_i;
        CFG_DIGIT_OFFSET:   off_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    job_d = job_q;
    if (in_xfer) begin
      job_d.below_one = (value_i[VALUE_W-1:FRAC_BITS] == '0);
      job_d.dec       = dec_q;
      job_d.offset    = off_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q <= DECIMAL_PLACES_RST;
      off_q <= DIGIT_OFFSET_RST;
    end else begin
      dec_q <= dec_d;
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  fpssd_scale #(
    .MAX_DIGITS (MAX_DIGITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .value_i (value_i),
    .dec_i   (dec_q),
    .busy_o  (scale_busy),
    .done_o  (scale_done),
    .num_o   (num)
  );

  fpssd_bcd #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scale_done),
    .num_i    (num),
    .busy_o   (bcd_busy),
    .done_o   (bcd_done),
    .digits_o (digits)
  );

  fpssd_writer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_writer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (bcd_done),
    .digits_i     (digits),
    .job_i        (job_q),
    .busy_o       (wr_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reg_addr_o   (reg_addr_o),
    .reg_data_o   (reg_data_o),
    .last_write_o (last_write_o)
  );

endmodule
